FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain check with a fixed message
`define BDIM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bdim assertion failed");

// check with a caller supplied message
`define BDIM_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`endif

FILE: hw/rtl/bdim_pkg.sv
// ----------------------------------------------------------------------------
// bdim_pkg
// Types, register map and factory tables of the two-channel button dimmer.
// ----------------------------------------------------------------------------
package bdim_pkg;

	localparam int NUM_PRESETS_DEF = 3;

	typedef enum logic [1:0] {
		MODE_STEADY   = 2'd0,
		MODE_ON       = 2'd1,
		MODE_FADE_OUT = 2'd2,
		MODE_RAMP     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		SAVE_NONE  = 2'd0,
		SAVE_LEVEL = 2'd1,
		SAVE_MASK  = 2'd2
	} save_t;

	// register indexes
	localparam logic [2:0] REG_FADE_INTERVAL     = 3'd0;
	localparam logic [2:0] REG_OFF_FADE_INTERVAL = 3'd1;
	localparam logic [2:0] REG_KEY_SAMPLE_RELOAD = 3'd2;
	localparam logic [2:0] REG_LONG_PRESS        = 3'd3;
	localparam logic [2:0] REG_SHORT_PRESS       = 3'd4;
	localparam logic [2:0] REG_DOUBLE_CLICK      = 3'd5;
	localparam logic [2:0] REG_MIN_LEVEL         = 3'd6;
	localparam logic [2:0] REG_MAX_LEVEL         = 3'd7;

	localparam logic [7:0] RST_FADE_INTERVAL     = 8'd6;
	localparam logic [7:0] RST_OFF_FADE_INTERVAL = 8'd17;
	localparam logic [7:0] RST_KEY_SAMPLE_RELOAD = 8'd6;
	localparam logic [7:0] RST_LONG_PRESS        = 8'd50;
	localparam logic [7:0] RST_SHORT_PRESS       = 8'd4;
	localparam logic [7:0] RST_DOUBLE_CLICK      = 8'd30;
	localparam logic [7:0] RST_MIN_LEVEL         = 8'd25;
	localparam logic [7:0] RST_MAX_LEVEL         = 8'd255;

	typedef struct packed {
		logic [7:0] fade_interval;
		logic [7:0] off_fade_interval;
		logic [7:0] key_sample_reload;
		logic [7:0] long_press_samples;
		logic [7:0] short_press_samples;
		logic [7:0] double_click_window;
		logic [7:0] min_level;
		logic [7:0] max_level;
	} cfg_t;

	typedef struct packed {
		logic [7:0] fade_timer;
		logic [7:0] sample_timer;
		logic [7:0] press_count;
		logic [7:0] click_window;
		logic [1:0] click_count;
		logic       long_held;
		logic       mask_pending;
		mode_t      mode;
		logic [7:0] target_level;
		logic       ramp_down;
		logic [1:0] active_preset;
		logic [1:0] channel_mask;
		logic [7:0] duty_a;
		logic [7:0] duty_b;
	} st_t;

	// preset slot update from the key logic
	typedef struct packed {
		logic       lvl_we;
		logic       ch_we;
		logic [1:0] idx;
		logic [7:0] lvl;
		logic [1:0] ch;
	} pwr_t;

	function automatic logic [7:0] factory_level(input int idx);
		case (idx)
			0:       factory_level = 8'd255;
			1:       factory_level = 8'd50;
			default: factory_level = 8'd255;
		endcase
	endfunction

	function automatic logic [1:0] factory_channels(input int idx);
		case (idx)
			0:       factory_channels = 2'd3;
			1:       factory_channels = 2'd2;
			default: factory_channels = 2'd1;
		endcase
	endfunction

endpackage

FILE: hw/rtl/bdim_cfg_regs.sv
// ----------------------------------------------------------------------------
// bdim_cfg_regs
// APB register file holding the eight timing and level settings.
// ----------------------------------------------------------------------------
module bdim_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output bdim_pkg::cfg_t     cfg
);

	bdim_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     idx;
	logic [7:0]     rd_val;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fade_interval       <= bdim_pkg::RST_FADE_INTERVAL;
			cfg_q.off_fade_interval   <= bdim_pkg::RST_OFF_FADE_INTERVAL;
			cfg_q.key_sample_reload   <= bdim_pkg::RST_KEY_SAMPLE_RELOAD;
			cfg_q.long_press_samples  <= bdim_pkg::RST_LONG_PRESS;
			cfg_q.short_press_samples <= bdim_pkg::RST_SHORT_PRESS;
			cfg_q.double_click_window <= bdim_pkg::RST_DOUBLE_CLICK;
			cfg_q.min_level           <= bdim_pkg::RST_MIN_LEVEL;
			cfg_q.max_level           <= bdim_pkg::RST_MAX_LEVEL;
		end else if (wr_en) begin
			case (idx)
				bdim_pkg::REG_FADE_INTERVAL:     cfg_q.fade_interval       <= pwdata[7:0];
				bdim_pkg::REG_OFF_FADE_INTERVAL: cfg_q.off_fade_interval   <= pwdata[7:0];
				bdim_pkg::REG_KEY_SAMPLE_RELOAD: cfg_q.key_sample_reload   <= pwdata[7:0];
				bdim_pkg::REG_LONG_PRESS:        cfg_q.long_press_samples  <= pwdata[7:0];
				bdim_pkg::REG_SHORT_PRESS:       cfg_q.short_press_samples <= pwdata[7:0];
				bdim_pkg::REG_DOUBLE_CLICK:      cfg_q.double_click_window <= pwdata[7:0];
				bdim_pkg::REG_MIN_LEVEL:         cfg_q.min_level           <= pwdata[7:0];
				bdim_pkg::REG_MAX_LEVEL:         cfg_q.max_level           <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			bdim_pkg::REG_FADE_INTERVAL:     rd_val = cfg_q.fade_interval;
			bdim_pkg::REG_OFF_FADE_INTERVAL: rd_val = cfg_q.off_fade_interval;
			bdim_pkg::REG_KEY_SAMPLE_RELOAD: rd_val = cfg_q.key_sample_reload;
			bdim_pkg::REG_LONG_PRESS:        rd_val = cfg_q.long_press_samples;
			bdim_pkg::REG_SHORT_PRESS:       rd_val = cfg_q.short_press_samples;
			bdim_pkg::REG_DOUBLE_CLICK:      rd_val = cfg_q.double_click_window;
			bdim_pkg::REG_MIN_LEVEL:         rd_val = cfg_q.min_level;
			bdim_pkg::REG_MAX_LEVEL:         rd_val = cfg_q.max_level;
			default:                         rd_val = 8'd0;
		endcase
	end

	assign prdata = {24'd0, rd_val};

endmodule

FILE: hw/rtl/bdim_fade.sv
// ----------------------------------------------------------------------------
// bdim_fade
// Fade engine: prescaler, target update and one duty step per channel, or a jump to the target on a mask change.
// ----------------------------------------------------------------------------
module bdim_fade #(
	parameter int NUM_PRESETS = bdim_pkg::NUM_PRESETS_DEF
) (
	input  bdim_pkg::st_t  st_i,
	input  bdim_pkg::cfg_t cfg,
	input  logic [7:0]     preset_level [NUM_PRESETS],
	input  logic [1:0]     preset_channels [NUM_PRESETS],
	output bdim_pkg::st_t  st_o
);

	always_comb begin
		bdim_pkg::st_t s;
		logic          slot_ok;
		logic [7:0]    p_lvl;
		logic [1:0]    p_ch;
		logic [7:0]    want_a;
		logic [7:0]    want_b;

		s       = st_i;
		slot_ok = 1'b0;
		p_lvl   = 8'd0;
		p_ch    = 2'd0;
		want_a  = 8'd0;
		want_b  = 8'd0;
		for (int p = 0; p < NUM_PRESETS; p++) begin
			if (st_i.active_preset == 2'(p)) begin
				slot_ok = 1'b1;
				p_lvl   = preset_level[p];
				p_ch    = preset_channels[p];
			end
		end

		if (st_i.fade_timer != 8'd0) begin
			s.fade_timer = st_i.fade_timer - 8'd1;
		end else begin
			s.fade_timer = cfg.fade_interval;
			case (st_i.mode)
				bdim_pkg::MODE_ON: begin
					// turn-on load: clamp level up, empty mask means channel A
					if (st_i.target_level == 8'd0 && slot_ok) begin
						s.target_level = (p_lvl < cfg.min_level) ? cfg.min_level : p_lvl;
						s.channel_mask = (p_ch == 2'd0) ? 2'd1 : p_ch;
					end
				end
				bdim_pkg::MODE_FADE_OUT: begin
					s.fade_timer   = cfg.off_fade_interval;
					s.target_level = 8'd0;
				end
				bdim_pkg::MODE_RAMP: begin
					if (!st_i.ramp_down && st_i.target_level < cfg.max_level)
						s.target_level = st_i.target_level + 8'd1;
					else if (st_i.ramp_down && st_i.target_level > cfg.min_level)
						s.target_level = st_i.target_level - 8'd1;
				end
				default: ;
			endcase

			want_a = s.channel_mask[0] ? s.target_level : 8'd0;
			want_b = s.channel_mask[1] ? s.target_level : 8'd0;

			if (st_i.mask_pending)         s.duty_a = want_a;
			else if (st_i.duty_a < want_a) s.duty_a = st_i.duty_a + 8'd1;
			else if (st_i.duty_a > want_a) s.duty_a = st_i.duty_a - 8'd1;

			if (st_i.mask_pending)         s.duty_b = want_b;
			else if (st_i.duty_b < want_b) s.duty_b = st_i.duty_b + 8'd1;
			else if (st_i.duty_b > want_b) s.duty_b = st_i.duty_b - 8'd1;

			s.mask_pending = 1'b0;
			if (s.duty_a == want_a && s.duty_b == want_b &&
			    st_i.mode != bdim_pkg::MODE_RAMP && st_i.press_count == 8'd0)
				s.mode = bdim_pkg::MODE_STEADY;
		end
		st_o = s;
	end

endmodule

FILE: hw/rtl/bdim_key.sv
// ----------------------------------------------------------------------------
// bdim_key
// Button evaluation: press timing, click counting and gesture actions.
// ----------------------------------------------------------------------------
module bdim_key #(
	parameter int NUM_PRESETS = bdim_pkg::NUM_PRESETS_DEF
) (
	input  bdim_pkg::st_t  st_i,
	input  bdim_pkg::cfg_t cfg,
	input  logic           down,
	output bdim_pkg::st_t  st_o,
	output bdim_pkg::save_t save,
	output bdim_pkg::pwr_t pwr
);

	always_comb begin
		bdim_pkg::st_t   s;
		bdim_pkg::save_t sv;
		bdim_pkg::pwr_t  w;
		logic [1:0]      clicked;
		logic            long_end;
		logic            slot_ok;

		s        = st_i;
		sv       = bdim_pkg::SAVE_NONE;
		w        = '0;
		clicked  = 2'd0;
		long_end = 1'b0;
		slot_ok  = 1'b0;

		if (st_i.sample_timer != 8'd0) begin
			s.sample_timer = st_i.sample_timer - 8'd1;
		end else begin
			s.sample_timer = cfg.key_sample_reload;
			if (down) begin
				if (s.press_count == 8'd0) s.click_window = cfg.double_click_window + 8'd1;
				if (s.click_window != 8'd0) s.click_window = s.click_window - 8'd1;
				if (s.press_count < cfg.long_press_samples) s.press_count = s.press_count + 8'd1;
				if (s.press_count == cfg.long_press_samples) s.long_held = 1'b1;
			end else begin
				if (s.press_count >= cfg.long_press_samples) begin
					long_end       = 1'b1;
					s.click_window = 8'd0;
					s.click_count  = 2'd0;
				end else begin
					if (s.press_count >= cfg.short_press_samples)
						s.click_count = s.click_count + 2'd1;
					if (s.click_window == 8'd0 || s.click_count == 2'd2) begin
						s.click_window = 8'd0;
						clicked        = s.click_count;
						s.click_count  = 2'd0;
					end else begin
						s.click_window = s.click_window - 8'd1;
					end
				end
				s.long_held   = 1'b0;
				s.press_count = 8'd0;
			end

			if (s.long_held) begin
				if (s.mode == bdim_pkg::MODE_STEADY && s.target_level != 8'd0) begin
					s.mode = bdim_pkg::MODE_RAMP;
					if (s.target_level == cfg.max_level)      s.ramp_down = 1'b1;
					else if (s.target_level == cfg.min_level) s.ramp_down = 1'b0;
				end else if (s.target_level == 8'd0 && NUM_PRESETS >= 2) begin
					s.active_preset = 2'd1;
					s.mode          = bdim_pkg::MODE_ON;
				end
			end

			slot_ok = int'(s.active_preset) < NUM_PRESETS;

			// end of a ramp stores the level in the active slot
			if (long_end && s.mode == bdim_pkg::MODE_RAMP) begin
				s.mode      = bdim_pkg::MODE_STEADY;
				s.ramp_down = ~s.ramp_down;
				w.lvl_we    = slot_ok;
				w.idx       = s.active_preset;
				w.lvl       = s.target_level;
				sv          = bdim_pkg::SAVE_LEVEL;
			end

			if (clicked == 2'd1) begin
				if (s.target_level == 8'd0) begin
					s.active_preset = 2'd0;
					s.mode          = bdim_pkg::MODE_ON;
				end else begin
					s.mode = bdim_pkg::MODE_FADE_OUT;
				end
			end else if (clicked == 2'd2) begin
				if (s.target_level == 8'd0 && NUM_PRESETS >= 3) begin
					s.active_preset = 2'd2;
					s.mode          = bdim_pkg::MODE_ON;
				end else if (s.target_level != 8'd0 && s.mode == bdim_pkg::MODE_STEADY) begin
					s.channel_mask = s.channel_mask + 2'd1;
					if (s.channel_mask == 2'd0) s.channel_mask = 2'd1;
					w.ch_we        = slot_ok;
					w.idx          = s.active_preset;
					w.ch           = s.channel_mask;
					s.mask_pending = 1'b1;
					sv             = bdim_pkg::SAVE_MASK;
				end
			end
		end
		st_o = s;
		save = sv;
		pwr  = w;
	end

endmodule

FILE: hw/rtl/button_dimmer_two_channel_core.sv
// ----------------------------------------------------------------------------
// button_dimmer_two_channel_core
// Two-channel push-button dimmer advanced by one tick request per PWM period.
// ----------------------------------------------------------------------------
// Path: an accepted tick is held in the input register, then evaluated and
//   written to the result register that drives res_valid. Throughput: one tick
//   per clock while tick_stall is low; input and result registers decouple the
//   sides, so a tick is taken while a result waits if the input register is empty.
// Reset (arst_n low, async): state and handshake cleared, registers back to
//   defaults, preset slots reloaded from the factory table at once.
`include "assert_macros.svh"

module button_dimmer_two_channel_core #(
	parameter int NUM_PRESETS = bdim_pkg::NUM_PRESETS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// tick channel
	input  logic        tick_valid,
	output logic        tick_stall,
	input  logic        button_down,
	// result channel
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  duty_a,
	output logic [7:0]  duty_b,
	output logic [1:0]  light_mode,
	output logic [7:0]  target_brightness,
	output logic [1:0]  save_event,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	bdim_pkg::cfg_t  cfg;
	bdim_pkg::st_t   st_q;
	bdim_pkg::st_t   st_fade;
	bdim_pkg::st_t   st_nxt;
	bdim_pkg::save_t save_nxt;
	bdim_pkg::pwr_t  pwr;

	// preset slots (stand-in for nonvolatile storage)
	logic [7:0] preset_level_q    [NUM_PRESETS];
	logic [1:0] preset_channels_q [NUM_PRESETS];

	// input stage
	logic valid_s1;
	logic down_s1;
	logic tick_acc;
	logic fire_s1;

	// result register
	logic       res_valid_q;
	logic [7:0] duty_a_q;
	logic [7:0] duty_b_q;
	logic [1:0] mode_q;
	logic [7:0] target_q;
	logic [1:0] save_q;

	bdim_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---- handshake ----
	// the held tick moves on whenever the result slot is free or being taken;
	// a new tick is refused only when both stages are full and the sink stalls
	assign fire_s1    = valid_s1 & ~(res_valid_q & res_stall);
	assign tick_stall = valid_s1 & res_valid_q & res_stall;
	assign tick_acc   = tick_valid & ~tick_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_acc) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) down_s1 <= button_down;
	end

	// ---- tick evaluation: fade step first, then the button ----
	bdim_fade #(.NUM_PRESETS(NUM_PRESETS)) u_fade (
		.st_i            (st_q),
		.cfg             (cfg),
		.preset_level    (preset_level_q),
		.preset_channels (preset_channels_q),
		.st_o            (st_fade)
	);

	bdim_key #(.NUM_PRESETS(NUM_PRESETS)) u_key (
		.st_i (st_fade),
		.cfg  (cfg),
		.down (down_s1),
		.st_o (st_nxt),
		.save (save_nxt),
		.pwr  (pwr)
	);

	// ---- controller state ----
	// all-zero state is steady mode with both channels dark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire_s1) begin
			st_q <= st_nxt;
		end
	end

	// preset slots, written on a level save or a mask change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PRESETS; p++) begin
				preset_level_q[p]    <= bdim_pkg::factory_level(p);
				preset_channels_q[p] <= bdim_pkg::factory_channels(p);
			end
		end else if (fire_s1) begin
			for (int p = 0; p < NUM_PRESETS; p++) begin
				if (pwr.lvl_we && pwr.idx == 2'(p)) preset_level_q[p]    <= pwr.lvl;
				if (pwr.ch_we && pwr.idx == 2'(p))  preset_channels_q[p] <= pwr.ch;
			end
		end
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			duty_a_q <= st_nxt.duty_a;
			duty_b_q <= st_nxt.duty_b;
			mode_q   <= st_nxt.mode;
			target_q <= st_nxt.target_level;
			save_q   <= save_nxt;
		end
	end

	assign res_valid         = res_valid_q;
	assign duty_a            = duty_a_q;
	assign duty_b            = duty_b_q;
	assign light_mode        = mode_q;
	assign target_brightness = target_q;
	assign save_event        = save_q;

	// ---- checks ----
	`BDIM_ASSERT_MSG(a_save_code, res_valid |-> save_event != 2'd3, "bad save code")
	`BDIM_ASSERT_MSG(a_state_hold, !fire_s1 |=> $stable(st_q), "state moved without a tick")
	`BDIM_ASSERT(a_s1_hold, (valid_s1 && tick_stall) |=> (valid_s1 && $stable(down_s1)))

endmodule
